>>> design/shae_pkg.sv
// shared types, constants and tables of the sha-256 engine
`default_nettype none

package shae_pkg;

    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned DIG_WORDS = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DIG_WORDS-1:0][WORD_W-1:0] digest_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_FILL,
        ST_COMP_LOAD,
        ST_COMP_RUN,
        ST_COMP_ADD
    } state_t;

    typedef struct packed {
        logic       load;
        logic       run;
        logic       commit;
        logic       init_iv;
        logic [5:0] rnd;
    } core_cmd_t;

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t r;
        unique case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] idx);
        word_t r;
        unique case (idx)
            6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
            6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
            6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
            6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
            6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
            6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/shae_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module shae_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/shae_core.sv
// compression datapath: working variables, schedule window and chaining words
`default_nettype none

module shae_core import shae_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire core_cmd_t cmd,
    input  wire word_t     w_mem,
    output digest_t        sum
);

    word_t h_reg [DIG_WORDS];
    word_t v_reg [DIG_WORDS];
    word_t w_reg [BLK_WORDS];
    word_t w_new;
    word_t t1;
    word_t t2;

    function automatic word_t bsig0(input word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic word_t bsig1(input word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic word_t ssig0(input word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic word_t ssig1(input word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    always_comb
    begin
        // first sixteen rounds take the block word straight from the ram
        if (cmd.rnd[5:4] == 2'b00)
        begin
            w_new = w_mem;
        end
        else
        begin
            w_new = ssig1(w_reg[14]) + w_reg[9] + ssig0(w_reg[1]) + w_reg[0];
        end
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(cmd.rnd) + w_new;
        t2 = bsig0(v_reg[0])
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        for (int i = 0; i < DIG_WORDS; i++)
        begin
            sum[i] = h_reg[i] + v_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < DIG_WORDS; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (cmd.run)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLK_WORDS-1] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIG_WORDS; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else if (cmd.init_iv)
        begin
            for (int i = 0; i < DIG_WORDS; i++)
            begin
                h_reg[i] <= iv_word(3'(i));
            end
        end
        else if (cmd.commit)
        begin
            for (int i = 0; i < DIG_WORDS; i++)
            begin
                h_reg[i] <= sum[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> design/shae_out.sv
// digest holding register and word-by-word output channel
`default_nettype none

module shae_out import shae_pkg::*; (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    capture,
    input  wire digest_t sum,
    input  wire logic    dig_stall,
    output logic         dig_valid,
    output word_t        digest_word,
    output logic [2:0]   word_index,
    output logic         last_word,
    output logic         busy
);

    word_t      dig_reg [DIG_WORDS];
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       busy_reg;
    logic       busy_next;

    assign dig_valid   = busy_reg;
    assign busy        = busy_reg;
    assign digest_word = dig_reg[cnt_reg];
    assign word_index  = cnt_reg;
    assign last_word   = (cnt_reg == 3'd7);

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (capture)
        begin
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg && !dig_stall)
        begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            for (int i = 0; i < DIG_WORDS; i++)
            begin
                dig_reg[i] <= sum[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

endmodule

`default_nettype wire

>>> design/sha256_hash_engine_top.sv
// sha-256 engine top level: byte packing, padding sequencer and block ram
// throughput: one message word per cycle while idle; every 64th byte starts a
//   compression (ram read plus 64 rounds at one per cycle, then the chaining add)
// reset: asynchronous, clears counters and the sequencer, loads the initial hash
//   values; the block ram is not cleared, every word is written before a block is read
`default_nettype none

module sha256_hash_engine_top import shae_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // message channel, one byte per word
    input  wire logic        msg_valid,
    output logic             msg_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        has_byte,
    input  wire logic        last_byte,
    // digest channel, eight words per message
    output logic             dig_valid,
    input  wire logic        dig_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    state_t      state_reg,    state_next;
    logic [5:0]  fill_reg,     fill_next;      // bytes pending in the block
    logic [23:0] pack_reg,     pack_next;      // bytes of the word being built
    logic [63:0] bits_reg,     bits_next;      // message length in bits, wraps
    logic [3:0]  pad_ptr_reg,  pad_ptr_next;
    logic [5:0]  rnd_reg,      rnd_next;
    logic        two_blk_reg,  two_blk_next;   // padding spills into a second block
    logic        final_reg,    final_next;     // block in flight carries the length
    logic        pad_pend_reg, pad_pend_next;  // last word filled a block, pad after it

    logic        msg_acc;
    logic        ram_we;
    logic [3:0]  ram_waddr;
    word_t       ram_wdata;
    logic [3:0]  ram_raddr;
    word_t       ram_rdata;
    core_cmd_t   cmd;
    digest_t     sum;
    logic        capture;
    logic        out_busy;

    // pending bytes of the partial word, then the 0x80 marker, then zeros
    function automatic word_t marker_word(input logic [1:0] k, input logic [23:0] p);
        word_t r;
        unique case (k)
            2'd0: r = 32'h8000_0000;
            2'd1: r = {p[7:0], 8'h80, 16'h0000};
            2'd2: r = {p[15:0], 8'h80, 8'h00};
            2'd3: r = {p[23:0], 8'h80};
        endcase
        return r;
    endfunction

    // input is taken only by the idle sequencer
    assign msg_stall = (state_reg != ST_IDLE);
    assign msg_acc   = msg_valid && !msg_stall;

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        pack_next     = pack_reg;
        bits_next     = bits_reg;
        pad_ptr_next  = pad_ptr_reg;
        rnd_next      = rnd_reg;
        two_blk_next  = two_blk_reg;
        final_next    = final_reg;
        pad_pend_next = pad_pend_reg;
        ram_we        = 1'b0;
        ram_waddr     = fill_reg[5:2];
        ram_wdata     = '0;
        ram_raddr     = 4'd0;
        cmd           = '0;
        capture       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_acc)
                begin
                    if (has_byte)
                    begin
                        pack_next = {pack_reg[15:0], data_byte};
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        // fourth byte completes a big-endian word
                        if (fill_reg[1:0] == 2'b11)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = {pack_reg, data_byte};
                        end
                    end
                    if (has_byte && (fill_reg == 6'd63))
                    begin
                        pad_pend_next = last_byte;
                        state_next    = ST_COMP_LOAD;
                    end
                    else if (last_byte)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end

            ST_PAD_MARK:
            begin
                ram_we       = 1'b1;
                ram_wdata    = marker_word(fill_reg[1:0], pack_reg);
                two_blk_next = (fill_reg[5:3] == 3'b111);
                final_next   = 1'b0;
                if (fill_reg[5:2] == 4'd15)
                begin
                    state_next = ST_COMP_LOAD;
                end
                else
                begin
                    pad_ptr_next = fill_reg[5:2] + 4'd1;
                    state_next   = ST_PAD_FILL;
                end
            end

            ST_PAD_FILL:
            begin
                ram_we       = 1'b1;
                ram_waddr    = pad_ptr_reg;
                pad_ptr_next = pad_ptr_reg + 4'd1;
                // length words close the block that carries no spilled marker
                if (!two_blk_reg && (pad_ptr_reg == 4'd14))
                begin
                    ram_wdata = bits_reg[63:32];
                end
                else if (!two_blk_reg && (pad_ptr_reg == 4'd15))
                begin
                    ram_wdata = bits_reg[31:0];
                end
                if (pad_ptr_reg == 4'd15)
                begin
                    final_next = !two_blk_reg;
                    state_next = ST_COMP_LOAD;
                end
            end

            ST_COMP_LOAD:
            begin
                cmd.load   = 1'b1;
                ram_raddr  = 4'd0;
                rnd_next   = 6'd0;
                state_next = ST_COMP_RUN;
            end

            ST_COMP_RUN:
            begin
                cmd.run   = 1'b1;
                cmd.rnd   = rnd_reg;
                // fetch the word for the next round now, so the registered ram read has it ready
                ram_raddr = rnd_reg[3:0] + 4'd1;
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_COMP_ADD;
                end
            end

            ST_COMP_ADD:
            begin
                priority if (two_blk_reg)
                begin
                    cmd.commit   = 1'b1;
                    two_blk_next = 1'b0;
                    pad_ptr_next = 4'd0;
                    state_next   = ST_PAD_FILL;
                end
                else if (final_reg)
                begin
                    // hold here until the previous digest has drained
                    if (!out_busy)
                    begin
                        capture       = 1'b1;
                        cmd.init_iv   = 1'b1;
                        final_next    = 1'b0;
                        pad_pend_next = 1'b0;
                        bits_next     = 64'd0;
                        fill_next     = 6'd0;
                        state_next    = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.commit = 1'b1;
                    if (pad_pend_reg)
                    begin
                        pad_pend_next = 1'b0;
                        state_next    = ST_PAD_MARK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= 6'd0;
            bits_reg     <= 64'd0;
            pad_ptr_reg  <= 4'd0;
            rnd_reg      <= 6'd0;
            two_blk_reg  <= 1'b0;
            final_reg    <= 1'b0;
            pad_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            bits_reg     <= bits_next;
            pad_ptr_reg  <= pad_ptr_next;
            rnd_reg      <= rnd_next;
            two_blk_reg  <= two_blk_next;
            final_reg    <= final_next;
            pad_pend_reg <= pad_pend_next;
        end
    end

    // partial word bytes are payload
    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
    end

    // sixteen-word block buffer
    shae_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLK_WORDS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    shae_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .w_mem (ram_rdata),
        .sum   (sum)
    );

    shae_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture     (capture),
        .sum         (sum),
        .dig_stall   (dig_stall),
        .dig_valid   (dig_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word),
        .busy        (out_busy)
    );

    // the block buffer must not change under the rounds reading it
    a_no_write_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP_RUN) |-> !ram_we)
        else $error("block ram written during compression");

    // a new digest never overwrites one still being sent
    a_capture_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        capture |-> !out_busy)
        else $error("digest captured while output busy");

    // the last round, 63, is followed by the chaining add
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP_RUN && rnd_reg == 6'd63) |=> (state_reg == ST_COMP_ADD))
        else $error("round counter out of step");

    // a plain data word advances the fill count by one
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_acc && has_byte && !last_byte && fill_reg != 6'd63)
        |=> (fill_reg == 6'($past(fill_reg) + 6'd1)))
        else $error("fill count did not advance");

endmodule

`default_nettype wire

>>> tb/sv/sha256_digest_checker.sv
`timescale 1ns / 100ps
// scoreboard for the sha-256 engine: follows message words, predicts digests, compares them
module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    input  logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last_byte,
    input  logic        dig_valid,
    input  logic        dig_stall,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          mismatch_count,
    output int          words_pending
);

    localparam logic [255:0] HASH_IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [2047:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  index;
        logic        is_last;
    } digest_entry_t;

    digest_entry_t digest_q[$];
    logic [255:0]  chain_value;
    logic [511:0]  block_bytes;
    logic [6:0]    fill_level;
    logic [63:0]   length_bits;
    int            errs;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // 64 rounds over one block, chaining add included
    function automatic logic [255:0] sha_compress(input logic [255:0] h_in,
                                                  input logic [511:0] blk);
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int i;
        for (i = 0; i < 16; i++)
            w[i] = blk[511 - 32 * i -: 32];
        for (i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d, e, f, g, h} = h_in;
        for (i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[2047 - 32 * i -: 32] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        return {a + h_in[255:224], b + h_in[223:192], c + h_in[191:160], d + h_in[159:128],
                e + h_in[127:96], f + h_in[95:64], g + h_in[63:32], h + h_in[31:0]};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_entry_t want;
        int pos;
        int k;
        if (!rst_n)
        begin
            digest_q.delete();
            chain_value = HASH_IV;
            block_bytes = '0;
            fill_level = '0;
            length_bits = '0;
            errs = 0;
            mismatch_count <= 0;
            words_pending <= 0;
        end
        else
        begin
            // digest side first: a word leaving now belongs to an earlier message
            if (dig_valid && !dig_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("%0t: digest word %h index %0d last %b with none expected",
                                 $realtime, digest_word, word_index, last_word);
                end
                else
                begin
                    want = digest_q.pop_front();
                    if (want.value !== digest_word || want.index !== word_index ||
                        want.is_last !== last_word)
                    begin
                        errs++;
                        if (errs <= 10)
                            $display("%0t: digest mismatch, expected %h/%0d/%b, got %h/%0d/%b",
                                     $realtime, want.value, want.index, want.is_last,
                                     digest_word, word_index, last_word);
                    end
                end
            end

            if (msg_valid && !msg_stall)
            begin
                if (has_byte)
                begin
                    block_bytes[511 - 8 * fill_level -: 8] = data_byte;
                    fill_level++;
                    if (fill_level == 7'd64)
                    begin
                        chain_value = sha_compress(chain_value, block_bytes);
                        length_bits += 64'd512;
                        fill_level = '0;
                    end
                end
                if (last_byte)
                begin
                    // marker byte, zero fill, spilling into a second block past byte 55
                    pos = fill_level;
                    block_bytes[511 - 8 * pos -: 8] = 8'h80;
                    pos++;
                    if (pos > 56)
                    begin
                        while (pos < 64)
                        begin
                            block_bytes[511 - 8 * pos -: 8] = 8'h00;
                            pos++;
                        end
                        chain_value = sha_compress(chain_value, block_bytes);
                        pos = 0;
                    end
                    while (pos < 56)
                    begin
                        block_bytes[511 - 8 * pos -: 8] = 8'h00;
                        pos++;
                    end
                    block_bytes[63:0] = length_bits + {54'd0, fill_level, 3'b000};
                    chain_value = sha_compress(chain_value, block_bytes);
                    for (k = 0; k < 8; k++)
                    begin
                        want.value = chain_value[255 - 32 * k -: 32];
                        want.index = 3'(k);
                        want.is_last = (k == 7);
                        digest_q.push_back(want);
                    end
                    chain_value = HASH_IV;
                    fill_level = '0;
                    length_bits = '0;
                end
            end
            mismatch_count <= errs;
            words_pending <= digest_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top for the sha-256 engine: clock, reset, message stimulus and verdict
module tb;

    // generous ceiling: a few hundred words, each with gaps, plus compression and stalls
    localparam int CYCLE_LIMIT = 400000;
    // a little more than the longest padding path of the engine
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_WORDS = 200;

    logic        clk;
    logic        rst_n;
    logic        msg_valid;
    logic        msg_stall;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_byte;
    logic        dig_valid;
    logic        dig_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int          mismatch_count;
    int          words_pending;
    int          words_sent;
    int          cycle_count = 0;
    bit          gaps_on;

    sha256_hash_engine_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .last_byte   (last_byte),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // the checker sits beside the engine and only watches both channels
    sha256_digest_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg_valid      (msg_valid),
        .msg_stall      (msg_stall),
        .data_byte      (data_byte),
        .has_byte       (has_byte),
        .last_byte      (last_byte),
        .dig_valid      (dig_valid),
        .dig_stall      (dig_stall),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .mismatch_count (mismatch_count),
        .words_pending  (words_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // digest receiver stalls at random, except during the quiet stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            dig_stall <= 1'b0;
        else
            dig_stall <= gaps_on && ($urandom_range(0, 99) < 28);
    end

    // presents one word and holds it until the engine takes it; the random gap before
    // it leaves valid low and the payload wandering, so nothing stale is ever accepted
    task automatic send_word(input logic [7:0] value, input logic has, input logic fin);
        // no idling at all for a stretch of words in the middle of the random part
        gaps_on = (words_sent < 90) || (words_sent >= 150);
        @(negedge clk);
        while (gaps_on && ($urandom_range(0, 99) < 28))
        begin
            msg_valid <= 1'b0;
            data_byte <= 8'($urandom_range(0, 255));
            @(negedge clk);
        end
        msg_valid <= 1'b1;
        data_byte <= value;
        has_byte  <= has;
        last_byte <= fin;
        @(posedge clk);
        while (msg_stall)
            @(posedge clk);
        // ignored words (no byte, not last) do not count as stimulus
        if (has || fin)
            words_sent++;
    endtask

    // one message of random bytes; the end is marked either on the final byte or by
    // a separate word with no byte, and ignored words are sprinkled in as noise
    task automatic send_message(input int len, input bit merged_end);
        int i;
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1, merged_end && (i == len - 1));
        end
        if (!merged_end || len == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // lowers valid and waits for every predicted digest word to leave the engine;
    // checked at the falling edge so that the checker's count is already current
    task automatic wait_for_digests;
        @(negedge clk);
        msg_valid <= 1'b0;
        while (words_pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int len;
        int pick;
        int msg_no;

        rst_n       = 1'b0;
        msg_valid   = 1'b0;
        data_byte   = 8'h00;
        has_byte    = 1'b0;
        last_byte   = 1'b0;
        words_sent  = 0;
        gaps_on     = 1'b1;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, a word with no byte that ends it
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        // single zero byte with the end mark on the same word
        send_word(8'h00, 1'b1, 1'b1);
        // an ignored word first, then extreme byte values, closed by a bare end word
        send_word(8'hff, 1'b0, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h7f, 1'b1, 1'b0);
        send_word(8'h01, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // the classic three-letter message
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);

        // hold off until the engine has handed out every digest so far
        wait_for_digests();

        // random messages; the first few sit on the padding boundaries: one block just
        // fits, length spills into a second block, a block filled by the final byte
        msg_no = 0;
        while (words_sent < RANDOM_WORDS + 11)
        begin
            case (msg_no)
                0: len = 55;
                1: len = 56;
                2: len = 64;
                3: len = 63;
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        len = $urandom_range(0, 12);
                    else if (pick < 8)
                        len = $urandom_range(52, 66);
                    else
                        len = $urandom_range(110, 130);
                end
            endcase
            send_message(len, (msg_no == 2) ? 1'b1 : 1'($urandom_range(0, 1)));
            msg_no++;
        end

        wait_for_digests();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && words_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
design/shae_pkg.sv
design/shae_ram.sv
design/shae_core.sv
design/shae_out.sv
design/sha256_hash_engine_top.sv
tb/sv/sha256_digest_checker.sv
tb/sv/tb.sv
